// ===== rtl/core/pmd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_pkg
// widths and constants shared by the detector tracker modules
// ----------------------------------------------------------------------------
package pmd_pkg;
    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int IDX_W      = 10;
    localparam int SUM_W      = 19;
    localparam int ACC_W      = 26;
    localparam int AVG_W      = 21;
    localparam int D_W        = 22;
    localparam int DEV_W      = 20;
    localparam int PER_W      = 20;
    localparam int CNT_W      = 16;
    localparam int SKIP_W     = 7;
    localparam int DIVR_W     = 22;
    localparam int MEAS_COUNT = 256;

    localparam logic [PER_W-1:0]  PER_ZERO_DEV = 20'd1000000;
    localparam logic [PER_W-1:0]  PER_MAX      = 20'hFFFFF;
    localparam logic [SKIP_W-1:0] SKIP_LIMIT   = 7'd64;
    localparam logic [CNT_W-1:0]  CNT_MAX      = 16'hFFFF;

    localparam logic [1:0] LED_OFF = 2'd0;
    localparam logic [1:0] LED_POS = 2'd1;
    localparam logic [1:0] LED_NEG = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WINDOW    = 2'd1;
    localparam logic [1:0] REG_ON_WINDOW = 2'd2;
    localparam logic [1:0] REG_BLANK     = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/core/pmd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pmd_div
    import pmd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [AVG_W-1:0]  dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   busy,
    output logic [AVG_W-1:0]       quotient
);
    localparam int CW = $clog2(AVG_W + 1);

    logic [CW-1:0]     cnt_reg;
    logic [AVG_W-1:0]  q_reg;
    logic [DIVR_W-1:0] d_reg;
    logic [DIVR_W:0]   rem_reg;
    logic [DIVR_W:0]   shifted;

    assign shifted  = {rem_reg[DIVR_W-1:0], q_reg[AVG_W-1]};
    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(AVG_W);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end else if (busy) begin
            // quotient bits shift in where dividend bits leave
            if (shifted >= {1'b0, d_reg}) begin
                rem_reg <= shifted - {1'b0, d_reg};
                q_reg   <= {q_reg[AVG_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[AVG_W-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pulse_metal_detect_tracker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_metal_detect_tracker_unit
// burst averaging, baseline tracking and flash-rate metal detection
// ----------------------------------------------------------------------------
// One request is taken at a time. A sample that does not close a burst goes
// from acceptance straight to the output stage, and the next request is taken
// only once its result has entered the output register. The last sample of a
// burst runs three arithmetic steps and the bit-serial divider (one quotient
// bit per cycle, then a step to collect the quotient) before its result is
// emitted; when the deviation is zero no division is needed and the divider
// is skipped. The output register holds a result until it is taken; a
// following result waits in the core until then.
module pulse_metal_detect_tracker_unit
    import pmd_pkg::*;
#(
    parameter int MEAS_CNT = MEAS_COUNT
)(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [SAMPLE_W-1:0]     s_sample,
    input  wire logic [TIME_W-1:0]       s_time_ms,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_led_state,
    output logic                         m_burst_done,
    output logic signed [DEV_W-1:0]      m_deviation,
    output logic [CNT_W-1:0]             m_flash_count,
    output logic                         m_metal_found
);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEAS_CNT + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_TRIM, ST_DEV, ST_ADAPT, ST_DIV, ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0]       thr_reg, win_reg;
    logic [7:0]        onw_reg;
    logic [PER_W-1:0]  blank_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= 16'd50;
            win_reg   <= 16'd500;
            onw_reg   <= 8'd10;
            blank_reg <= 20'd1000;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_THRESHOLD: thr_reg   <= pwdata[15:0];
                REG_WINDOW:    win_reg   <= pwdata[15:0];
                REG_ON_WINDOW: onw_reg   <= pwdata[7:0];
                REG_BLANK:     blank_reg <= pwdata[PER_W-1:0];
                default:       thr_reg   <= thr_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = {16'd0, thr_reg};
            REG_WINDOW:    prdata = {16'd0, win_reg};
            REG_ON_WINDOW: prdata = {24'd0, onw_reg};
            REG_BLANK:     prdata = {12'd0, blank_reg};
            default:       prdata = '0;
        endcase
    end

    // tracker state
    logic [IDX_W-1:0]        idx_reg;
    logic [SAMPLE_W-1:0]     min_reg, max_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [SKIP_W-1:0]       skip_reg;
    logic signed [DEV_W-1:0] dev_reg;
    logic [PER_W-1:0]        per_reg;
    logic [TIME_W-1:0]       fstart_reg, wstart_reg, now_reg;
    logic [CNT_W-1:0]        run_reg, lat_reg;
    logic                    found_reg;
    logic [SUM_W-1:0]        trim_reg;
    logic [AVG_W-1:0]        avg_reg;
    logic signed [D_W-1:0]   d_reg;
    logic [1:0]              led_reg;
    logic                    done_reg;

    logic                    s_acc;
    logic [SAMPLE_W-1:0]     min_next, max_next;
    logic [SUM_W-1:0]        sum_next;
    logic [1:0]              led_next;
    logic                    in_on, past_per;
    logic [SAMPLE_W:0]       trim_sum;
    logic [SUM_W-1:0]        trimmed;
    logic [ACC_W-1:0]        seed, acc_seeded;
    logic [ACC_W:0]          avg_sum;
    logic [D_W-1:0]          ad;
    logic                    adapt;
    logic [SKIP_W-1:0]       skip_next;
    logic                    div_start, div_busy;
    logic [AVG_W-1:0]        quo;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;

    assign min_next = (s_sample < min_reg) ? s_sample : min_reg;
    assign max_next = (s_sample > max_reg) ? s_sample : max_reg;
    assign sum_next = sum_reg + SUM_W'(s_sample);
    assign in_on    = s_time_ms < (fstart_reg + TIME_W'(onw_reg));
    assign past_per = s_time_ms > (fstart_reg + TIME_W'(per_reg));

    always_comb begin
        led_next = LED_OFF;
        if (in_on || past_per) begin
            if (dev_reg > 0) led_next = LED_POS;
            if (dev_reg < 0) led_next = LED_NEG;
        end
        if (per_reg > blank_reg) led_next = LED_OFF;
    end

    assign trim_sum   = {1'b0, min_reg} + {1'b0, max_reg};
    assign trimmed    = (sum_reg >= SUM_W'(trim_sum)) ? sum_reg - SUM_W'(trim_sum) : '0;
    assign seed       = {1'b0, trim_reg, 6'd0};
    assign acc_seeded = (acc_reg == '0) ? {1'b0, trimmed, 6'd0} : acc_reg;
    assign avg_sum    = {1'b0, acc_reg} + (ACC_W+1)'(32);
    assign ad         = d_reg[D_W-1] ? D_W'(-d_reg) : D_W'(d_reg);
    assign adapt      = ad < D_W'(avg_reg[AVG_W-1:10]);
    assign skip_next  = adapt ? '0 : skip_reg + 1'b1;
    assign div_start  = (state_reg == ST_ADAPT) && (d_reg != '0);

    pmd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (avg_reg),
        .divisor  ({ad[D_W-2:0], 1'b0}),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            sum_reg    <= '0;
            acc_reg    <= '0;
            skip_reg   <= '0;
            dev_reg    <= '0;
            per_reg    <= '0;
            fstart_reg <= '0;
            wstart_reg <= '0;
            run_reg    <= '0;
            lat_reg    <= '0;
            found_reg  <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            if (m_valid && m_ready && state_reg != ST_EMIT) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        min_reg <= min_next;
                        max_reg <= max_next;
                        sum_reg <= sum_next;
                        now_reg <= s_time_ms;
                        led_reg <= led_next;
                        if (in_on && dev_reg > 0 && run_reg != CNT_MAX)
                            run_reg <= run_reg + 1'b1;
                        if (past_per) fstart_reg <= s_time_ms;
                        if (idx_reg >= LAST_IDX) begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_TRIM;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            done_reg  <= 1'b0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_TRIM: begin
                    trim_reg <= trimmed;
                    acc_reg  <= acc_seeded;
                    if ((now_reg - wstart_reg) >= TIME_W'(win_reg)) begin
                        wstart_reg <= now_reg;
                        lat_reg    <= run_reg;
                        run_reg    <= '0;
                        found_reg  <= run_reg > thr_reg;
                    end
                    idx_reg   <= '0;
                    min_reg   <= '1;
                    max_reg   <= '0;
                    sum_reg   <= '0;
                    state_reg <= ST_DEV;
                end
                ST_DEV: begin
                    avg_reg   <= AVG_W'(avg_sum[ACC_W:6]);
                    d_reg     <= D_W'({1'b0, trim_reg}) - D_W'(avg_sum[ACC_W:6]);
                    state_reg <= ST_ADAPT;
                end
                ST_ADAPT: begin
                    if (skip_next > SKIP_LIMIT) begin
                        acc_reg  <= seed;
                        skip_reg <= '0;
                    end else begin
                        skip_reg <= skip_next;
                        if (adapt) acc_reg <= acc_reg + ACC_W'(d_reg);
                    end
                    if (d_reg > D_W'(524287))
                        dev_reg <= DEV_W'(524287);
                    else if (d_reg < -D_W'(524288))
                        dev_reg <= DEV_W'(-524288);
                    else
                        dev_reg <= DEV_W'(d_reg);
                    if (d_reg == '0) begin
                        per_reg   <= PER_ZERO_DEV;
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!div_busy) begin
                        per_reg   <= (quo > AVG_W'(PER_MAX)) ? PER_MAX : PER_W'(quo);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid || m_ready) begin
                        m_valid       <= 1'b1;
                        m_led_state   <= led_reg;
                        m_burst_done  <= done_reg;
                        m_deviation   <= dev_reg;
                        m_flash_count <= lat_reg;
                        m_metal_found <= found_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pmd_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_chk
// port-level checks for the detector tracker, bound to the top level
// ----------------------------------------------------------------------------
module pmd_chk (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       pready,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_led_state
);
    // only one request in flight
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one in flight");

    a_led_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_led_state != 2'd3)
        else $error("invalid led state");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_state))
        else $error("result dropped while stalled");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");
endmodule

bind pulse_metal_detect_tracker_unit pmd_chk u_pmd_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .pready      (pready),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_led_state (m_led_state)
);
`default_nettype wire
